### rtl/umpq_pkg.sv
// ----------------------------------------------------------------------------
// umpq_pkg
// Shared types and constants for the unsorted max priority queue: item
// structs, status and kind codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package umpq_pkg;

  // queue depth and derived widths
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VAL_W    = 32;
  localparam int OCC_W    = 5;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // input item
  typedef struct packed {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic ins;       // insert the accepted value
    logic rm_empty;  // remove on an empty queue
    logic rm_start;  // begin a scan at slot 0
    logic scan;      // read one slot and advance
    logic swap;      // move last entry into the winner's slot
    logic load_out;  // push pending result into the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

### rtl/unsorted_max_priority_queue.sv
// ----------------------------------------------------------------------------
// unsorted_max_priority_queue
// Max priority queue of signed 32-bit values kept as an unsorted array.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_valid/in_stall/in_data; kind 0 inserts value,
//   kind 1 removes the largest stored value (lowest slot on ties).
//   Every item yields exactly one result item on out_valid/out_stall/out_data
//   with the removed value (else zero), a status and the occupancy after it.
//   Insert: item taken, result held in the pending register, then loaded
//   into the output register; next item taken the cycle after the result
//   is loaded, so no item is taken while one is in progress. Remove with n
//   stored entries: the scan reads one memory slot per cycle, then a drain
//   state empties the read pipe and a swap state writes the tail entry into
//   the freed slot. Remove on an empty queue acts like insert.
//   A full insert or empty remove changes nothing and reports a status.
//   Reset empties the queue and clears the output valid flag; memory
//   contents are left as they are and need no clearing.
//   The output register holds a finished result while out_stall is high;
//   the block then waits before loading the next result and stalls input.
// ----------------------------------------------------------------------------
module unsorted_max_priority_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  umpq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output umpq_pkg::out_item_t out_data
);
  import umpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  umpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and scan datapath
  umpq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/umpq_ctrl.sv
// ----------------------------------------------------------------------------
// umpq_ctrl
// Sequencer for the queue: takes items, steps the datapath through the
// slot scan and swap of a remove, and hands each result to the output.
// ----------------------------------------------------------------------------
module umpq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_stall,
  input  umpq_pkg::sts_t sts,
  output umpq_pkg::cmd_t cmd
);
  import umpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SWAP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_INSERT) begin
            cmd.ins   = 1'b1;
            state_nxt = S_DONE;
          end else if (sts.empty) begin
            cmd.rm_empty = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            cmd.rm_start = 1'b1;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_SWAP;
      end
      S_SWAP: begin
        cmd.swap  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### rtl/umpq_dpath.sv
// ----------------------------------------------------------------------------
// umpq_dpath
// Entry memory, count, scan pipeline with running maximum, pending result
// and the output register of the queue.
// ----------------------------------------------------------------------------
module umpq_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  umpq_pkg::in_item_t  in_data,
  input  umpq_pkg::cmd_t      cmd,
  output umpq_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_stall,
  output umpq_pkg::out_item_t out_data
);
  import umpq_pkg::*;

  // entry memory
  logic [VAL_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        cnt_m1;
  logic [IDX_W-1:0]        scan_idx_r;
  logic [IDX_W-1:0]        rd_idx_r;
  logic [VAL_W-1:0]        rd_data_r;
  logic                    rd_vld_r;
  logic signed [VAL_W-1:0] best_r;
  logic [IDX_W-1:0]        best_slot_r;
  logic [VAL_W-1:0]        last_r;
  logic signed [VAL_W-1:0] res_value_r;
  logic [1:0]              res_status_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;
  logic                    full;

  assign full   = (count_r == CNT_W'(CAPACITY));
  assign cnt_m1 = count_r - CNT_W'(1);

  // memory write port and registered read
  always_ff @(posedge clk) begin
    if (cmd.ins && !full) begin
      mem[count_r[IDX_W-1:0]] <= in_data.value;
    end else if (cmd.swap) begin
      mem[best_slot_r] <= last_r;
    end
    rd_data_r <= mem[scan_idx_r];
    rd_idx_r  <= scan_idx_r;
  end

  // scan address and read-valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.rm_start) begin
        scan_idx_r <= '0;
      end else if (cmd.scan) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
    end
  end

  // running maximum, first slot wins on ties; last read is the tail entry
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      last_r <= rd_data_r;
      if (rd_idx_r == '0 || $signed(rd_data_r) > best_r) begin
        best_r      <= $signed(rd_data_r);
        best_slot_r <= rd_idx_r;
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.ins && !full) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.swap) begin
      count_r <= cnt_m1;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      res_value_r  <= '0;
      res_status_r <= full ? STATUS_FULL : STATUS_OK;
    end else if (cmd.rm_empty) begin
      res_value_r  <= '0;
      res_status_r <= STATUS_EMPTY;
    end else if (cmd.swap) begin
      res_value_r  <= best_r;
      res_status_r <= STATUS_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.result_value <= res_value_r;
      out_data_r.status       <= res_status_r;
      out_data_r.occupancy    <= OCC_W'(count_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.empty     = (count_r == '0);
  assign sts.scan_last = (scan_idx_r == cnt_m1[IDX_W-1:0]);
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

### rtl/umpq_chk.sv
// ----------------------------------------------------------------------------
// umpq_chk
// Port-level checks for the unsorted max priority queue, bound to the top.
// ----------------------------------------------------------------------------
module umpq_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input umpq_pkg::out_item_t out_data
);
  import umpq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset clears the output valid flag
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a rejected insert reports a full queue and no value
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_FULL |->
      out_data.occupancy == OCC_W'(CAPACITY) && out_data.result_value == '0)
    else $error("full status with wrong occupancy or value");

  // an empty remove reports no entries and no value
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_EMPTY |->
      out_data.occupancy == '0 && out_data.result_value == '0)
    else $error("empty status with entries or value");

  // no item is taken while the previous result is still loading
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted during processing");

endmodule

bind unsorted_max_priority_queue umpq_chk u_umpq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
